// ----- sv/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and byte-level functions for the AES block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_KEYLEN = 3'd4;

  // key length codes
  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_256 = 2'd2;
  localparam logic [1:0] KLEN_BAD = 2'd3;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } aes_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_block;   // capture input block
    logic       round_en;     // run one cipher round
    logic       last_round;   // round without mix columns
    logic       decrypt;
    logic       exp_init;     // start expansion
    logic       exp_step;     // produce one expanded word
    logic [5:0] rk_addr;      // round-key word address for current round
  } aes_cmd_t;

  // datapath status
  typedef struct packed {
    logic exp_done;
  } aes_stat_t;

  function automatic logic [7:0] sbox_f(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] sbox_i(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox_f(w[31:24]), sbox_f(w[23:16]), sbox_f(w[15:8]), sbox_f(w[7:0])};
  endfunction

  // forward mix of one column, byte 0 in bits 31:24
  function automatic logic [31:0] mix_fwd(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  // inverse mix: premultiply by {05,00,04,00} then forward mix
  function automatic logic [31:0] mix_inv(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xt(xt(a0 ^ a2));
    v = xt(xt(a1 ^ a3));
    return mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

endpackage

`default_nettype wire

// ----- sv/aes_datapath.sv -----
// ----------------------------------------------------------------------------
// AES datapath
// State register, shared round unit, key expansion and the round-key memory.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_datapath
  import aes_pkg::*;
#(
  parameter int RK_WORDS = 60
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire aes_cmd_t     cmd,
  output aes_stat_t         stat,
  input  wire logic [255:0] key,
  input  wire logic [1:0]   key_len,
  input  wire logic [127:0] blk_in,
  output logic [127:0]      blk_out
);

  localparam int AW = $clog2(RK_WORDS);

  // round-key memory: words gathered four to a row, one row read per round
  logic [127:0] rk_mem [RK_WORDS/4];
  logic [31:0]  win_r [8];     // sliding window of last nk words
  logic [31:0]  win_nxt [8];
  logic [5:0]   widx_r, widx_nxt;   // index of next word to generate
  logic [2:0]   kmod_r, kmod_nxt;   // widx mod nk
  logic [7:0]   rcon_r, rcon_nxt;
  logic [5:0]   total;
  logic [3:0]   nk;
  logic [2:0]   nk_last;            // window slot of the newest word
  logic [31:0]  prev, tword, newword;
  logic [127:0] rk_q;
  logic [127:0] st_r, st_nxt;

  assign nk    = (key_len == KLEN_128) ? 4'd4 : (key_len == KLEN_192) ? 4'd6 : 4'd8;
  assign total = (key_len == KLEN_128) ? 6'd44 : (key_len == KLEN_192) ? 6'd52 : 6'd60;
  assign nk_last = 3'(nk - 4'd1);

  // next expanded word from the window (window holds words i-nk .. i-1)
  always_comb begin
    prev = win_r[nk_last];
    if (kmod_r == 3'd0)
      tword = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_r, 24'h0};
    else if (nk == 4'd8 && kmod_r == 3'd4)
      tword = sub_word(prev);
    else
      tword = prev;
    newword = win_r[0] ^ tword;
  end

  // expansion sequencer: words 0..nk-1 come from the key, then one per cycle
  always_comb begin
    for (int i = 0; i < 8; i++) win_nxt[i] = win_r[i];
    widx_nxt = widx_r;
    kmod_nxt = kmod_r;
    rcon_nxt = rcon_r;
    if (cmd.exp_init) begin
      for (int i = 0; i < 8; i++) win_nxt[i] = key[255 - 32*i -: 32];
      widx_nxt = 6'(nk);
      kmod_nxt = 3'd0;
      rcon_nxt = 8'h01;
    end else if (cmd.exp_step) begin
      for (int i = 0; i < 7; i++)
        win_nxt[i] = (4'(i) < nk - 4'd1) ? win_r[i + 1] : win_r[i];
      win_nxt[nk_last] = newword;
      widx_nxt = widx_r + 6'd1;
      kmod_nxt = (kmod_r == nk_last) ? 3'd0 : kmod_r + 3'd1;
      if (kmod_r == 3'd0) rcon_nxt = xt(rcon_r);
    end
  end

  assign stat.exp_done = (widx_r >= total);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) win_r[i] <= win_nxt[i];
    widx_r <= widx_nxt;
    kmod_r <= kmod_nxt;
    rcon_r <= rcon_nxt;
  end

  // memory write: key words at init, then each new word
  // row buffer starts with key words 4..7 so a 192-bit key keeps words 4 and 5
  logic [127:0] row_buf_r, row_buf_nxt;
  always_comb begin
    row_buf_nxt = row_buf_r;
    if (cmd.exp_init) row_buf_nxt = key[127:0];
    else if (cmd.exp_step) row_buf_nxt[127 - 32*widx_r[1:0] -: 32] = newword;
  end

  always_ff @(posedge clk) begin
    row_buf_r <= row_buf_nxt;
    if (cmd.exp_init) begin
      rk_mem[0] <= key[255:128];
      if (nk != 4'd4) rk_mem[1] <= key[127:0];
    end else if (cmd.exp_step && widx_r[1:0] == 2'd3) begin
      rk_mem[widx_r[5:2]] <= row_buf_nxt;
    end
    rk_q <= rk_mem[cmd.rk_addr[AW-1:2]];
  end

  // one round of the shared round unit
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0]   b [16];
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++)
        b[4*c + k] = sbox_f(s[127 - 8*(4*((c + k) % 4) + k) -: 8]);
    for (int c = 0; c < 4; c++) begin
      r[127 - 32*c -: 32] = {b[4*c], b[4*c+1], b[4*c+2], b[4*c+3]};
      if (!last) r[127 - 32*c -: 32] = mix_fwd(r[127 - 32*c -: 32]);
    end
    return r;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++)
        r[127 - 8*(4*c + k) -: 8] = sbox_i(s[127 - 8*(4*((c + 4 - k) % 4) + k) -: 8]);
    return r;
  endfunction

  // decrypt: state holds block after add key; round = invshift, invsub, addkey, invmix
  logic [127:0] dec_k;
  always_comb begin
    st_nxt = st_r;
    dec_k  = dec_round(st_r) ^ rk_q;
    if (cmd.load_block)
      st_nxt = blk_in;
    else if (cmd.round_en) begin
      if (!cmd.decrypt)
        st_nxt = enc_round(st_r, cmd.last_round) ^ rk_q;
      else if (cmd.last_round)
        st_nxt = dec_k;
      else
        for (int c = 0; c < 4; c++)
          st_nxt[127 - 32*c -: 32] = mix_inv(dec_k[127 - 32*c -: 32]);
    end else if (cmd.exp_init == 1'b0 && cmd.rk_addr[0]) begin
      // initial key addition
      st_nxt = st_r ^ rk_q;
    end
  end

  always_ff @(posedge clk) st_r <= st_nxt;
  assign blk_out = st_r;

  // unused reset kept for control-free datapath
  logic unused_rst;
  assign unused_rst = rst_n;

endmodule

`default_nettype wire

// ----- sv/aes_ctrl.sv -----
// ----------------------------------------------------------------------------
// AES controller
// Sequences key expansion and the rounds of one block.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_ctrl
  import aes_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       op,
  input  wire logic [1:0] key_len,
  input  wire logic       cfg_wr,
  input  wire aes_stat_t  stat,
  output aes_cmd_t        cmd,
  output logic            busy,
  output logic            done,
  output logic            err
);

  aes_state_t st_r, st_nxt;
  logic       ready_r, ready_nxt;
  logic       dec_r, dec_nxt;
  logic [3:0] rnd_r, rnd_nxt;   // round counter
  logic       ph_r, ph_nxt;     // 0: address issued, 1: data valid
  logic       err_r, err_nxt;
  logic [3:0] nr;

  assign nr = (key_len == KLEN_128) ? 4'd10 : (key_len == KLEN_192) ? 4'd12 : 4'd14;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      ready_r <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ready_r <= ready_nxt;
      err_r   <= err_nxt;
    end
    dec_r <= dec_nxt;
    rnd_r <= rnd_nxt;
    ph_r  <= ph_nxt;
  end

  // round key row for the round about to run
  logic [3:0] krow;
  assign krow = dec_r ? nr - rnd_r : rnd_r;

  always_comb begin
    st_nxt    = st_r;
    ready_nxt = ready_r;
    dec_nxt   = dec_r;
    rnd_nxt   = rnd_r;
    ph_nxt    = ph_r;
    err_nxt   = err_r;
    cmd       = '0;
    cmd.decrypt = dec_r;
    cmd.rk_addr = {krow, 2'b00};
    done      = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          dec_nxt = op;
          rnd_nxt = 4'd0;
          ph_nxt  = 1'b0;
          cmd.load_block = 1'b1;
          if (key_len == KLEN_BAD) begin
            err_nxt = 1'b1;
            st_nxt  = ST_DONE;
          end else if (!ready_r) begin
            err_nxt = 1'b0;
            cmd.exp_init = 1'b1;
            st_nxt  = ST_EXPAND;
          end else begin
            err_nxt = 1'b0;
            st_nxt  = ST_LOAD;
          end
        end
      end
      ST_EXPAND: begin
        cmd.exp_step = !stat.exp_done;
        if (stat.exp_done) begin
          ready_nxt = 1'b1;
          st_nxt    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // read first key row, then add it
        if (ph_r) begin
          cmd.rk_addr = {krow, 2'b01};
          rnd_nxt = 4'd1;
          ph_nxt  = 1'b0;
          st_nxt  = ST_ROUND;
        end else
          ph_nxt = 1'b1;
      end
      ST_ROUND: begin
        if (ph_r) begin
          cmd.round_en   = 1'b1;
          cmd.last_round = (rnd_r == nr);
          ph_nxt  = 1'b0;
          rnd_nxt = rnd_r + 4'd1;
          if (rnd_r == nr) st_nxt = ST_DONE;
        end else
          ph_nxt = 1'b1;
      end
      ST_DONE: begin
        done   = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (cfg_wr) ready_nxt = 1'b0;
  end

  assign busy = (st_r != ST_IDLE);
  assign err  = err_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DONE |=> st_r == ST_IDLE) else $error("done not followed by idle");
  a_exp_ready: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_EXPAND && stat.exp_done && !cfg_wr |=> ready_r)
    else $error("keys not marked ready");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_ROUND |-> rnd_r <= nr) else $error("round count overrun");

endmodule

`default_nettype wire

// ----- sv/aes_block_cipher.sv -----
// ----------------------------------------------------------------------------
// AES block cipher
// Encrypts or decrypts one 128-bit block with a 128-, 192- or 256-bit key.
// ----------------------------------------------------------------------------
// A block is taken when start is high and busy low; the result appears with
// out_valid for one cycle and cannot be held off. Each round reads its round
// key from memory then runs the shared round unit; the next block can be taken
// only once the result of the last one has been shown. The first block after
// reset or any key write first expands the key, one word per cycle. An invalid
// key length answers with zero and out_key_error in the cycle after the block
// is taken.
`default_nettype none

module aes_block_cipher
  import aes_pkg::*;
#(
  parameter int ROUND_KEY_WORDS = 60
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [63:0] in_block_high,
  input  wire logic [63:0] in_block_low,
  output logic             out_valid,
  output logic [63:0]      out_result_high,
  output logic [63:0]      out_result_low,
  output logic             out_key_error,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0]  key_r [4];
  logic [1:0]   klen_r, klen_eff;
  aes_cmd_t     cmd;
  aes_stat_t    stat;
  logic [127:0] blk;
  logic         done, err, cfg_hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      klen_r <= KLEN_256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0:   key_r[0] <= cfg_data;
        REG_KEY1:   key_r[1] <= cfg_data;
        REG_KEY2:   key_r[2] <= cfg_data;
        REG_KEY3:   key_r[3] <= cfg_data;
        REG_KEYLEN: klen_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_hit = cfg_we && (cfg_index <= REG_KEYLEN);

  // the invalid length code and key lengths whose schedule does not fit the store are rejected
  always_comb begin
    klen_eff = klen_r;
    if (klen_r == KLEN_BAD ||
        (klen_r == KLEN_128 && ROUND_KEY_WORDS < 44) ||
        (klen_r == KLEN_192 && ROUND_KEY_WORDS < 52) ||
        (klen_r == KLEN_256 && ROUND_KEY_WORDS < 60))
      klen_eff = KLEN_BAD;
  end

  aes_ctrl u_ctrl (
    .clk, .rst_n, .start, .op(in_op), .key_len(klen_eff), .cfg_wr(cfg_hit),
    .stat, .cmd, .busy, .done, .err
  );

  aes_datapath #(.RK_WORDS(ROUND_KEY_WORDS)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .key({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .key_len(klen_eff),
    .blk_in({in_block_high, in_block_low}),
    .blk_out(blk)
  );

  assign out_valid       = done;
  assign out_result_high = err ? 64'h0 : blk[127:64];
  assign out_result_low  = err ? 64'h0 : blk[63:0];
  assign out_key_error   = err;

endmodule

`default_nettype wire

// ----- test/aes_block_cipher_checker.sv -----
// ----------------------------------------------------------------------------
// AES block cipher checker
// Watches the key register port and the item channels, predicts each block's
// result and compares it field by field against what comes out of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_block_cipher_checker
  import aes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        in_op,
  input  wire logic [63:0] in_block_high,
  input  wire logic [63:0] in_block_low,
  input  wire logic        out_valid,
  input  wire logic [63:0] out_result_high,
  input  wire logic [63:0] out_result_low,
  input  wire logic        out_key_error,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        err;
  } cipher_result_t;

  cipher_result_t expected_blocks[$];

  logic [63:0] key_regs [4];
  logic [1:0]  key_len;
  logic [7:0]  fwd_sbox [256];
  logic [7:0]  inv_sbox [256];

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) acc ^= a;
      a = xtime(a);
      b = b >> 1;
    end
    return acc;
  endfunction

  // S-boxes built from the field inverse and the affine map
  initial begin
    logic [7:0] b, s;
    for (int a = 0; a < 256; a++) begin
      b = 8'h00;
      for (int c = 1; c < 256; c++)
        if (a != 0 && gmul(a[7:0], c[7:0]) == 8'h01) b = c[7:0];
      s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
          ^ 8'h63;
      fwd_sbox[a] = s;
      inv_sbox[s] = a[7:0];
    end
  end

  function automatic logic [31:0] sub_w(input logic [31:0] w);
    return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
  endfunction

  function automatic logic [127:0] sub_state(input logic [127:0] st, input logic inv);
    for (int i = 0; i < 16; i++)
      st[127-8*i -: 8] = inv ? inv_sbox[st[127-8*i -: 8]] : fwd_sbox[st[127-8*i -: 8]];
    return st;
  endfunction

  // row r rotates left by r, or right by r for the inverse
  function automatic logic [127:0] shift_state(input logic [127:0] st, input logic inv);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
        t[127-8*(4*c+r) -: 8] = st[127-8*(4*src+r) -: 8];
      end
    return t;
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] st, input logic inv);
    logic [7:0] m [4];
    logic [7:0] a [4];
    logic [7:0] o;
    if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = st[127-8*(4*c+k) -: 8];
      for (int r = 0; r < 4; r++) begin
        o = 8'h00;
        for (int k = 0; k < 4; k++) o ^= gmul(a[k], m[(k + 4 - r) % 4]);
        st[127-8*(4*c+r) -: 8] = o;
      end
    end
    return st;
  endfunction

  // full cipher from the current key registers
  function automatic cipher_result_t aes_predict(input logic op, input logic [63:0] hi,
                                                 input logic [63:0] lo);
    logic [31:0]    w [60];
    logic [31:0]    tmp;
    logic [7:0]     rc;
    logic [127:0]   st;
    cipher_result_t res;
    int nk, nr;
    res = '{hi: 64'h0, lo: 64'h0, err: 1'b1};
    if (key_len == KLEN_BAD) return res;
    nk = (key_len == KLEN_128) ? 4 : (key_len == KLEN_192) ? 6 : 8;
    nr = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      w[i] = (i % 2 == 0) ? key_regs[i/2][63:32] : key_regs[i/2][31:0];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      tmp = w[i-1];
      if (i % nk == 0) begin
        tmp = sub_w({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
        rc = xtime(rc);
      end else if (nk > 6 && i % nk == 4) begin
        tmp = sub_w(tmp);
      end
      w[i] = w[i-nk] ^ tmp;
    end
    st = {hi, lo};
    if (op == OP_ENC) begin
      st ^= {w[0], w[1], w[2], w[3]};
      for (int rd = 1; rd <= nr; rd++) begin
        st = shift_state(sub_state(st, 1'b0), 1'b0);
        if (rd < nr) st = mix_state(st, 1'b0);
        st ^= {w[4*rd], w[4*rd+1], w[4*rd+2], w[4*rd+3]};
      end
    end else begin
      st ^= {w[4*nr], w[4*nr+1], w[4*nr+2], w[4*nr+3]};
      for (int rd = nr - 1; rd >= 0; rd--) begin
        st = sub_state(shift_state(st, 1'b1), 1'b1);
        st ^= {w[4*rd], w[4*rd+1], w[4*rd+2], w[4*rd+3]};
        if (rd > 0) st = mix_state(st, 1'b1);
      end
    end
    res = '{hi: st[127:64], lo: st[63:0], err: 1'b0};
    return res;
  endfunction

  // sample everything at the rising edge
  always @(posedge clk) begin
    cipher_result_t exp_res;
    if (!rst_n) begin
      key_regs <= '{64'h0, 64'h0, 64'h0, 64'h0};
      key_len  <= KLEN_256;
      expected_blocks.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_KEYLEN) key_len <= cfg_data[1:0];
        else if (cfg_index <= REG_KEY3) key_regs[cfg_index[1:0]] <= cfg_data;
      end
      if (out_valid) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: result with nothing expected: %h %h err %b", $time,
                   out_result_high, out_result_low, out_key_error);
          fail_count <= fail_count + 1;
        end else begin
          exp_res = expected_blocks.pop_front();
          if (out_result_high !== exp_res.hi || out_result_low !== exp_res.lo ||
              out_key_error !== exp_res.err) begin
            if (out_result_high !== exp_res.hi)
              $display("%0t: result_high expected %h actual %h", $time, exp_res.hi,
                       out_result_high);
            if (out_result_low !== exp_res.lo)
              $display("%0t: result_low expected %h actual %h", $time, exp_res.lo,
                       out_result_low);
            if (out_key_error !== exp_res.err)
              $display("%0t: key_error expected %b actual %b", $time, exp_res.err,
                       out_key_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_blocks.push_back(aes_predict(in_op, in_block_high, in_block_low));
      pending <= expected_blocks.size();
    end
  end

endmodule

`default_nettype wire

// ----- test/aes_block_cipher_tb.sv -----
// ----------------------------------------------------------------------------
// AES block cipher testbench
// Drives known vectors and random blocks under many key settings, with random
// sender gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_block_cipher_tb
  import aes_pkg::*;
;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = OP_ENC;
  logic [63:0] in_block_high = 64'h0;
  logic [63:0] in_block_low = 64'h0;
  logic        out_valid;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;
  logic        out_key_error;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_KEY0;
  logic [63:0] cfg_data = 64'h0;
  int          fail_count;
  int          pending;
  int          item_count = 0;

  always #10 clk = ~clk;

  aes_block_cipher dut (.*);

  aes_block_cipher_checker checker_i (.*);

  // one item; returns once the block has taken it
  task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
    @(negedge clk);
    start = 1'b1;
    in_op = op;
    in_block_high = hi;
    in_block_low = lo;
    do @(posedge clk); while (busy);
    item_count++;
  endtask

  task automatic idle_for(input int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // wait until every result is back and the block is quiet
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3,
                          input logic [1:0] klen);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    write_reg(REG_KEYLEN, klen);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [63:0] rand64;
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'h0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [1:0] klen;
    int burst;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // reset key: all zero, 256 bit
    send_block(OP_ENC, 64'h0, 64'h0);
    send_block(OP_DEC, 64'h0, 64'h0);
    drain();

    // standard 128/192/256 test keys
    for (int k = 0; k < 3; k++) begin
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
               64'h1011121314151617, 64'h18191a1b1c1d1e1f, k[1:0]);
      send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(OP_DEC, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(OP_ENC, '1, '1);
      drain();
    end

    // all-ones key, then the invalid length
    load_key('1, '1, '1, '1, KLEN_256);
    send_block(OP_ENC, 64'h0, '1);
    send_block(OP_DEC, '1, 64'h0);
    drain();
    load_key('1, '1, '1, '1, KLEN_BAD);
    send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OP_DEC, '1, '1);
    drain();

    // unused register indexes are ignored
    write_reg(3'd5, '1);
    write_reg(3'd7, '1);
    write_reg(REG_KEYLEN, KLEN_128);
    @(negedge clk);
    cfg_we = 1'b0;
    send_block(OP_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(OP_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();

    // random phases, each with its own key
    while (item_count < 520) begin
      klen = ($urandom_range(0, 9) == 0) ? KLEN_BAD : 2'($urandom_range(0, 2));
      load_key(rand64(), rand64(), rand64(), rand64(), klen);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(3'($urandom_range(5, 7)), rand64());
        @(negedge clk);
        cfg_we = 1'b0;
      end
      repeat ($urandom_range(20, 60)) begin
        if (item_count < 440 && $urandom_range(0, 2) == 0) begin
          burst = $urandom_range(1, 18);
          idle_for(burst);
        end
        send_block(1'($urandom_range(0, 1)), rand64(), rand64());
      end
      drain();
    end

    repeat (40) @(negedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
